// ===== design/rlm_pkg.sv =====
`default_nettype none

package rlm_pkg;

  localparam int unsigned ShadowBytes = 24;
  localparam int unsigned NumLeds     = 48;

  typedef logic [5:0] upc_t;
  typedef logic [4:0] sidx_t;

  typedef enum logic [2:0] {
    OP_INIT     = 3'd0,
    OP_SET_RGB  = 3'd1,
    OP_ALL_ON   = 3'd2,
    OP_ALL_OFF  = 3'd3,
    OP_LOW_OFF  = 3'd4,
    OP_HIGH_OFF = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    COLOR_RED,
    COLOR_GREEN,
    COLOR_BLUE
  } color_e;

  typedef enum logic [2:0] {
    SRC_CONST,
    SRC_PWM_ADDR,
    SRC_LEVEL,
    SRC_POS,
    SRC_SHADOW,
    SRC_FILL
  } src_e;

  typedef enum logic [1:0] {
    EOT_NO,
    EOT_YES,
    EOT_AT_END
  } eot_e;

  typedef enum logic [1:0] {
    LAST_NO,
    LAST_AT_END,
    LAST_AT_BLUE
  } last_e;

  typedef enum logic [1:0] {
    SH_NONE,
    SH_FILL,
    SH_SET_BIT,
    SH_CLR_BIT
  } sh_e;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_CLEAR,
    CNT_INC,
    CNT_NEXT_COLOR
  } cnt_e;

  typedef enum logic [1:0] {
    JMP_NEXT,
    JMP_ALWAYS,
    JMP_LOOP,
    JMP_LEVEL_ZERO
  } jmp_e;

  // One control word of the microprogram.
  typedef struct packed {
    logic       emit;
    src_e       src;
    logic [7:0] const_byte;
    eot_e       eot;
    last_e      last;
    sh_e        sh_op;
    cnt_e       cnt;
    jmp_e       jmp;
    upc_t       target;
    sidx_t      limit;
  } uword_t;

  // Sequencer to datapath controls.
  typedef struct packed {
    logic       load;
    logic       sh_we;
    src_e       src;
    logic [7:0] const_byte;
    logic       eot;
    logic       last;
    sh_e        sh_op;
    sidx_t      idx;
    color_e     color;
  } dp_ctl_t;

  // Program labels.
  localparam upc_t UpcInit      = 6'd0;
  localparam upc_t UpcFill      = 6'd12;
  localparam upc_t UpcFillLoop  = 6'd17;
  localparam upc_t UpcLowHalf   = 6'd18;
  localparam upc_t UpcLowLoop   = 6'd23;
  localparam upc_t UpcHighHalf  = 6'd24;
  localparam upc_t UpcHighKeep  = 6'd29;
  localparam upc_t UpcHighClear = 6'd30;
  localparam upc_t UpcRgb       = 6'd31;
  localparam upc_t UpcRgbClear  = 6'd38;
  localparam upc_t UpcRgbOnoff  = 6'd39;

  // Bus bytes.
  localparam logic [7:0] UnlockReg     = 8'hFE;
  localparam logic [7:0] UnlockKey     = 8'hC5;
  localparam logic [7:0] PageReg       = 8'hFD;
  localparam logic [7:0] PageOnoff     = 8'h00;
  localparam logic [7:0] PagePwm       = 8'h01;
  localparam logic [7:0] PageFunc      = 8'h03;
  localparam logic [7:0] ShutdownReg   = 8'h00;
  localparam logic [7:0] ShutdownExit  = 8'h01;
  localparam logic [7:0] GccReg        = 8'h01;
  localparam logic [7:0] GccValue      = 8'd127;
  localparam logic [7:0] OnoffStartReg = 8'h00;

  localparam sidx_t LastShadowIdx = 5'(ShadowBytes - 1);
  localparam sidx_t LastLowIdx    = 5'(ShadowBytes / 2 - 1);

endpackage

`default_nettype wire

// ===== design/rlm_ucode_rom.sv =====
`default_nettype none

module rlm_ucode_rom (
  input  rlm_pkg::upc_t   upc_i,
  output rlm_pkg::uword_t uword_o
);
  import rlm_pkg::*;

  function automatic uword_t put(logic [7:0] b, logic eot);
    uword_t w;
    w            = '0;
    w.emit       = 1'b1;
    w.src        = SRC_CONST;
    w.const_byte = b;
    w.eot        = eot ? EOT_YES : EOT_NO;
    return w;
  endfunction

  function automatic uword_t put_src(src_e s, eot_e eot);
    uword_t w;
    w      = '0;
    w.emit = 1'b1;
    w.src  = s;
    w.eot  = eot;
    return w;
  endfunction

  // Shadow loop step: emit the source, advance the index, close at limit.
  function automatic uword_t loop_step(src_e s, sh_e sh, logic closing, upc_t tgt,
                                       sidx_t lim);
    uword_t w;
    w        = put_src(s, closing ? EOT_AT_END : EOT_NO);
    w.last   = closing ? LAST_AT_END : LAST_NO;
    w.sh_op  = sh;
    w.cnt    = CNT_INC;
    w.jmp    = JMP_LOOP;
    w.target = tgt;
    w.limit  = lim;
    return w;
  endfunction

  uword_t uw;

  always_comb begin
    uw = '0;
    case (upc_i)
      // init: shutdown exit, global current, then the all-off fill
      6'd0:  uw = put(UnlockReg, 1'b0);
      6'd1:  uw = put(UnlockKey, 1'b1);
      6'd2:  uw = put(PageReg, 1'b0);
      6'd3:  uw = put(PageFunc, 1'b1);
      6'd4:  uw = put(ShutdownReg, 1'b0);
      6'd5:  uw = put(ShutdownExit, 1'b1);
      6'd6:  uw = put(UnlockReg, 1'b0);
      6'd7:  uw = put(UnlockKey, 1'b1);
      6'd8:  uw = put(PageReg, 1'b0);
      6'd9:  uw = put(PageFunc, 1'b1);
      6'd10: uw = put(GccReg, 1'b0);
      6'd11: uw = put(GccValue, 1'b1);
      // all on / all off
      6'd12: uw = put(UnlockReg, 1'b0);
      6'd13: uw = put(UnlockKey, 1'b1);
      6'd14: uw = put(PageReg, 1'b0);
      6'd15: uw = put(PageOnoff, 1'b1);
      6'd16: begin
        uw     = put(OnoffStartReg, 1'b0);
        uw.cnt = CNT_CLEAR;
      end
      6'd17: uw = loop_step(SRC_FILL, SH_FILL, 1'b1, UpcFillLoop, LastShadowIdx);
      // low half off
      6'd18: uw = put(UnlockReg, 1'b0);
      6'd19: uw = put(UnlockKey, 1'b1);
      6'd20: uw = put(PageReg, 1'b0);
      6'd21: uw = put(PageOnoff, 1'b1);
      6'd22: begin
        uw     = put(OnoffStartReg, 1'b0);
        uw.cnt = CNT_CLEAR;
      end
      6'd23: uw = loop_step(SRC_FILL, SH_FILL, 1'b1, UpcLowLoop, LastLowIdx);
      // high half off: resend low half, clear high half
      6'd24: uw = put(UnlockReg, 1'b0);
      6'd25: uw = put(UnlockKey, 1'b1);
      6'd26: uw = put(PageReg, 1'b0);
      6'd27: uw = put(PageOnoff, 1'b1);
      6'd28: begin
        uw     = put(OnoffStartReg, 1'b0);
        uw.cnt = CNT_CLEAR;
      end
      6'd29: uw = loop_step(SRC_SHADOW, SH_NONE, 1'b0, UpcHighKeep, LastLowIdx);
      6'd30: uw = loop_step(SRC_FILL, SH_FILL, 1'b1, UpcHighClear, LastShadowIdx);
      // set rgb led, once per colour
      6'd31: begin
        uw.jmp    = JMP_LEVEL_ZERO;
        uw.target = UpcRgbClear;
      end
      6'd32: uw = put(UnlockReg, 1'b0);
      6'd33: uw = put(UnlockKey, 1'b1);
      6'd34: uw = put(PageReg, 1'b0);
      6'd35: uw = put(PagePwm, 1'b1);
      6'd36: uw = put_src(SRC_PWM_ADDR, EOT_NO);
      6'd37: begin
        uw        = put_src(SRC_LEVEL, EOT_YES);
        uw.sh_op  = SH_SET_BIT;
        uw.jmp    = JMP_ALWAYS;
        uw.target = UpcRgbOnoff;
      end
      6'd38: uw.sh_op = SH_CLR_BIT;
      6'd39: uw = put(UnlockReg, 1'b0);
      6'd40: uw = put(UnlockKey, 1'b1);
      6'd41: uw = put(PageReg, 1'b0);
      6'd42: uw = put(PageOnoff, 1'b1);
      6'd43: uw = put_src(SRC_POS, EOT_NO);
      6'd44: begin
        uw        = put_src(SRC_SHADOW, EOT_YES);
        uw.last   = LAST_AT_BLUE;
        uw.cnt    = CNT_NEXT_COLOR;
        uw.jmp    = JMP_ALWAYS;
        uw.target = UpcRgb;
      end
      default: uw = '0;
    endcase
  end

  assign uword_o = uw;

endmodule

`default_nettype wire

// ===== design/rlm_sequencer.sv =====
`default_nettype none

module rlm_sequencer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_fire_i,
  input  logic [2:0]        start_op_i,
  input  logic [5:0]        start_led_i,
  input  rlm_pkg::uword_t   uword_i,
  input  logic              level_zero_i,
  input  logic              out_free_i,
  output rlm_pkg::upc_t     upc_o,
  output logic              busy_o,
  output rlm_pkg::dp_ctl_t  ctl_o
);
  import rlm_pkg::*;

  logic   busy_q, busy_d;
  upc_t   upc_q, upc_d;
  sidx_t  idx_q, idx_d;
  color_e col_q, col_d;

  logic     advance;
  logic     at_end;
  dp_ctl_t  ctl;
  upc_t     entry;
  logic     start_ok;

  always_comb begin
    at_end  = (idx_q == uword_i.limit);
    advance = busy_q && (!uword_i.emit || out_free_i);

    ctl            = '0;
    ctl.load       = advance && uword_i.emit;
    ctl.sh_we      = advance && (uword_i.sh_op != SH_NONE);
    ctl.src        = uword_i.src;
    ctl.const_byte = uword_i.const_byte;
    ctl.sh_op      = uword_i.sh_op;
    ctl.idx        = idx_q;
    ctl.color      = col_q;
    case (uword_i.eot)
      EOT_YES:    ctl.eot = 1'b1;
      EOT_AT_END: ctl.eot = at_end;
      default:    ctl.eot = 1'b0;
    endcase
    case (uword_i.last)
      LAST_AT_END:  ctl.last = at_end;
      LAST_AT_BLUE: ctl.last = (col_q == COLOR_BLUE);
      default:      ctl.last = 1'b0;
    endcase

    // Entry point of each command; unknown ops and bad LEDs never start.
    entry    = UpcInit;
    start_ok = 1'b1;
    case (op_e'(start_op_i))
      OP_INIT:     entry = UpcInit;
      OP_SET_RGB: begin
        entry    = UpcRgb;
        start_ok = (start_led_i < 6'(NumLeds));
      end
      OP_ALL_ON:   entry = UpcFill;
      OP_ALL_OFF:  entry = UpcFill;
      OP_LOW_OFF:  entry = UpcLowHalf;
      OP_HIGH_OFF: entry = UpcHighHalf;
      default:     start_ok = 1'b0;
    endcase

    busy_d = busy_q;
    upc_d  = upc_q;
    idx_d  = idx_q;
    col_d  = col_q;
    if (in_fire_i) begin
      busy_d = start_ok;
      upc_d  = entry;
      idx_d  = '0;
      col_d  = COLOR_RED;
    end else if (advance) begin
      if (ctl.load && ctl.last) begin
        busy_d = 1'b0;
      end
      case (uword_i.jmp)
        JMP_ALWAYS:     upc_d = uword_i.target;
        JMP_LOOP:       upc_d = at_end ? upc_q + 6'd1 : uword_i.target;
        JMP_LEVEL_ZERO: upc_d = level_zero_i ? uword_i.target : upc_q + 6'd1;
        default:        upc_d = upc_q + 6'd1;
      endcase
      case (uword_i.cnt)
        CNT_CLEAR:      idx_d = '0;
        CNT_INC:        idx_d = idx_q + 5'd1;
        CNT_NEXT_COLOR: col_d = color_e'(col_q + 2'd1);
        default:        idx_d = idx_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      upc_q  <= UpcInit;
      idx_q  <= '0;
      col_q  <= COLOR_RED;
    end else begin
      busy_q <= busy_d;
      upc_q  <= upc_d;
      idx_q  <= idx_d;
      col_q  <= col_d;
    end
  end

  assign upc_o  = upc_q;
  assign busy_o = busy_q;
  assign ctl_o  = ctl;

endmodule

`default_nettype wire

// ===== design/rlm_datapath.sv =====
`default_nettype none

module rlm_datapath (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_fire_i,
  input  logic [2:0]       op_i,
  input  logic [7:0]       device_addr_i,
  input  logic [5:0]       led_index_i,
  input  logic [7:0]       red_level_i,
  input  logic [7:0]       green_level_i,
  input  logic [7:0]       blue_level_i,
  input  rlm_pkg::dp_ctl_t ctl_i,
  input  logic             out_ready_i,
  output logic             level_zero_o,
  output logic             out_free_o,
  output logic             out_valid_o,
  output logic [7:0]       bus_addr_o,
  output logic [7:0]       data_byte_o,
  output logic             end_of_transfer_o,
  output logic             last_o
);
  import rlm_pkg::*;

  // LED number to row group and column; odd groups run right to left.
  function automatic logic [5:0] led_map(logic [5:0] led);
    logic [1:0] grp;
    logic [5:0] k;
    logic [3:0] cs;
    if (led < 6'd12) begin
      grp = 2'd0;
      k   = led;
    end else if (led < 6'd24) begin
      grp = 2'd1;
      k   = led - 6'd12;
    end else if (led < 6'd36) begin
      grp = 2'd2;
      k   = led - 6'd24;
    end else begin
      grp = 2'd3;
      k   = led - 6'd36;
    end
    cs = grp[0] ? 4'(6'd11 - k) : k[3:0];
    return {grp, cs};
  endfunction

  op_e        op_q;
  logic [7:0] dev_q;
  logic [1:0] grp_q;
  logic [3:0] cs_q;
  logic [7:0] red_q, green_q, blue_q;

  logic [7:0] shadow_q [0:ShadowBytes-1];

  logic       out_valid_q;
  logic [7:0] bus_addr_q, data_q;
  logic       eot_q, last_q;

  logic [3:0] sw;
  sidx_t      pos, rd_addr, wr_addr;
  logic [7:0] mask, pwm_addr, level, fill, shadow_rd, wr_data, byte_sel;

  always_ff @(posedge clk_i) begin
    if (in_fire_i) begin
      op_q          <= op_e'(op_i);
      dev_q         <= device_addr_i;
      {grp_q, cs_q} <= led_map(led_index_i);
      red_q         <= red_level_i;
      green_q       <= green_level_i;
      blue_q        <= blue_level_i;
    end
  end

  always_comb begin
    sw       = {1'b0, grp_q, 1'b0} + {2'b00, grp_q} + {2'b00, ctl_i.color};
    pos      = {sw, cs_q[3]};
    mask     = 8'd1 << cs_q[2:0];
    pwm_addr = 8'(({4'b0000, sw} + 8'd1) * ({4'b0000, cs_q} + 8'd1) - 8'd1);
    case (ctl_i.color)
      COLOR_RED:   level = red_q;
      COLOR_GREEN: level = green_q;
      COLOR_BLUE:  level = blue_q;
      default:     level = red_q;
    endcase
    fill      = (op_q == OP_ALL_ON) ? 8'hFF : 8'h00;
    rd_addr   = (op_q == OP_SET_RGB) ? pos : ctl_i.idx;
    shadow_rd = shadow_q[rd_addr];

    wr_addr = pos;
    case (ctl_i.sh_op)
      SH_FILL: begin
        wr_addr = ctl_i.idx;
        wr_data = fill;
      end
      SH_SET_BIT: wr_data = shadow_rd | mask;
      SH_CLR_BIT: wr_data = shadow_rd & ~mask;
      default:    wr_data = shadow_rd;
    endcase

    case (ctl_i.src)
      SRC_CONST:    byte_sel = ctl_i.const_byte;
      SRC_PWM_ADDR: byte_sel = pwm_addr;
      SRC_LEVEL:    byte_sel = level;
      SRC_POS:      byte_sel = {3'b000, pos};
      SRC_SHADOW:   byte_sel = shadow_rd;
      SRC_FILL:     byte_sel = fill;
      default:      byte_sel = ctl_i.const_byte;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ShadowBytes; i++) begin
        shadow_q[i] <= 8'h00;
      end
    end else if (ctl_i.sh_we) begin
      shadow_q[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      bus_addr_q <= dev_q;
      data_q     <= byte_sel;
      eot_q      <= ctl_i.eot;
      last_q     <= ctl_i.last;
    end
  end

  assign level_zero_o      = (level == 8'h00);
  assign out_free_o        = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign bus_addr_o        = bus_addr_q;
  assign data_byte_o       = data_q;
  assign end_of_transfer_o = eot_q;
  assign last_o            = last_q;

endmodule

`default_nettype wire

// ===== design/rgb_led_matrix_write_sequencer_top.sv =====
// RGB LED matrix write sequencer.
// Input channel (in_valid_i/in_ready_o) takes one command per transfer: op, bus
// address of the driver chip, LED number and three colour levels. Output channel
// (out_valid_o/out_ready_i) gives one bus byte per transfer, in bus order, with
// end_of_transfer_o on the final byte of each bus write and last_o on the final
// byte of the command.
// A microprogram in a 45-word table steps a byte-wide datapath; the step counter
// advances once per cycle unless a byte step finds the output register full, so
// throughput is one byte per cycle while the receiver keeps up. A command is
// registered into the step counter, then its first byte is loaded into the output
// register. Bytes per command: 41 for init, 29 for all on / all off / high half
// off, 17 for low half off; set rgb gives 6 or 12 bytes per colour and also runs
// a decision step per colour and one more per zero colour; these emit no byte,
// and those of red come before the first byte.
// in_ready_o drops while a program runs and rises once the last byte is loaded,
// so the next command is taken while that byte still waits in the output register.
// Unknown ops and LED numbers above 47 are taken and dropped with no output.
// When the receiver stalls, the output register holds and the program waits.
// Reset clears the 24-byte on/off shadow directly in its flops and leaves the
// block idle and ready.
`default_nettype none

module rgb_led_matrix_write_sequencer_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] op_i,
  input  logic [7:0] device_addr_i,
  input  logic [5:0] led_index_i,
  input  logic [7:0] red_level_i,
  input  logic [7:0] green_level_i,
  input  logic [7:0] blue_level_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] bus_addr_o,
  output logic [7:0] data_byte_o,
  output logic       end_of_transfer_o,
  output logic       last_o
);
  import rlm_pkg::*;

  logic    in_fire;
  logic    busy;
  logic    level_zero;
  logic    out_free;
  upc_t    upc;
  uword_t  uword;
  dp_ctl_t ctl;

  // Take a command only between programs.
  assign in_ready_o = !busy;
  assign in_fire    = in_valid_i && in_ready_o;

  // Control store: one word per step.
  rlm_ucode_rom u_rom (
    .upc_i   (upc),
    .uword_o (uword)
  );

  // Step counter, loop index, colour counter and jumps.
  rlm_sequencer u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_fire_i    (in_fire),
    .start_op_i   (op_i),
    .start_led_i  (led_index_i),
    .uword_i      (uword),
    .level_zero_i (level_zero),
    .out_free_i   (out_free),
    .upc_o        (upc),
    .busy_o       (busy),
    .ctl_o        (ctl)
  );

  // Operands, on/off shadow, byte select and output register.
  rlm_datapath u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_fire_i         (in_fire),
    .op_i              (op_i),
    .device_addr_i     (device_addr_i),
    .led_index_i       (led_index_i),
    .red_level_i       (red_level_i),
    .green_level_i     (green_level_i),
    .blue_level_i      (blue_level_i),
    .ctl_i             (ctl),
    .out_ready_i       (out_ready_i),
    .level_zero_o      (level_zero),
    .out_free_o        (out_free),
    .out_valid_o       (out_valid_o),
    .bus_addr_o        (bus_addr_o),
    .data_byte_o       (data_byte_o),
    .end_of_transfer_o (end_of_transfer_o),
    .last_o            (last_o)
  );

endmodule

`default_nettype wire

// ===== design/rlm_checker.sv =====
`default_nettype none

module rlm_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] bus_addr_o,
  input logic [7:0] data_byte_o,
  input logic       end_of_transfer_o,
  input logic       last_o
);

  // A stalled byte holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(data_byte_o)
      && $stable(bus_addr_o) && $stable(last_o) && $stable(end_of_transfer_o))
    else $error("stalled output byte changed");

  // The final byte of a command closes a bus write.
  a_last_eot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> end_of_transfer_o)
    else $error("last byte without end of transfer");

  // Ready returns only once the last byte of the command is loaded.
  a_ready_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_ready_o) |-> out_valid_o && last_o)
    else $error("input ready rose before the last byte");

endmodule

bind rgb_led_matrix_write_sequencer_top rlm_checker u_rlm_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_ready_o        (in_ready_o),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .bus_addr_o        (bus_addr_o),
  .data_byte_o       (data_byte_o),
  .end_of_transfer_o (end_of_transfer_o),
  .last_o            (last_o)
);

`default_nettype wire

// ===== tb/rlm_write_checker.sv =====
`timescale 1ns / 100ps

module rlm_write_checker
  import rlm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic [2:0] op_i,
  input  logic [7:0] device_addr_i,
  input  logic [5:0] led_index_i,
  input  logic [7:0] red_level_i,
  input  logic [7:0] green_level_i,
  input  logic [7:0] blue_level_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic [7:0] bus_addr_i,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_transfer_i,
  input  logic       last_i,
  output int         fail_count_o,
  output int         pending_o
);

  typedef struct packed {
    logic [7:0] addr;
    logic [7:0] data;
    logic       eot;
    logic       last;
  } bus_byte_t;

  bus_byte_t  pending_bytes[$];
  logic [7:0] onoff_copy [ShadowBytes];
  logic [7:0] cmd_addr;

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    fail_count_o = fail_count_o + 1;
  endtask

  task automatic queue_byte(input logic [7:0] value, input logic eot);
    bus_byte_t item;
    item.addr = cmd_addr;
    item.data = value;
    item.eot  = eot;
    item.last = 1'b0;
    pending_bytes.push_back(item);
  endtask

  task automatic queue_pair(input logic [7:0] reg_addr, input logic [7:0] value);
    queue_byte(reg_addr, 1'b0);
    queue_byte(value, 1'b1);
  endtask

  task automatic queue_prelude(input logic [7:0] page);
    queue_pair(UnlockReg, UnlockKey);
    queue_pair(PageReg, page);
  endtask

  task automatic queue_fill(input logic [7:0] value);
    queue_prelude(PageOnoff);
    queue_byte(OnoffStartReg, 1'b0);
    for (int i = 0; i < ShadowBytes; i++) begin
      onoff_copy[i] = value;
      queue_byte(value, i == ShadowBytes - 1);
    end
  endtask

  task automatic queue_pixel(input int unsigned sw, input int unsigned cs,
                             input logic [7:0] level);
    int unsigned pos;
    logic [7:0]  mask;
    logic [7:0]  pwm_addr;
    pos      = (sw * 2 + (cs > 7 ? 1 : 0)) % ShadowBytes;
    mask     = 8'(1 << (cs % 8));
    pwm_addr = 8'((sw + 1) * (cs + 1) - 1);
    if (level == 8'd0) begin
      onoff_copy[pos] = onoff_copy[pos] & ~mask;
    end else begin
      queue_prelude(PagePwm);
      queue_pair(pwm_addr, level);
      onoff_copy[pos] = onoff_copy[pos] | mask;
    end
    queue_prelude(PageOnoff);
    queue_pair(8'(pos), onoff_copy[pos]);
  endtask

  // Append the bus bytes of one command and advance the on/off copy.
  task automatic predict_command(input logic [2:0] op, input logic [7:0] addr,
                                 input logic [5:0] led, input logic [7:0] red,
                                 input logic [7:0] green, input logic [7:0] blue);
    int unsigned group;
    int unsigned k;
    int unsigned cs;
    int          start;
    logic [7:0]  levels [3];
    bus_byte_t   tail;
    start     = pending_bytes.size();
    cmd_addr  = addr;
    levels[0] = red;
    levels[1] = green;
    levels[2] = blue;
    case (op)
      OP_INIT: begin
        queue_prelude(PageFunc);
        queue_pair(ShutdownReg, ShutdownExit);
        queue_prelude(PageFunc);
        queue_pair(GccReg, GccValue);
        queue_fill(8'h00);
      end
      OP_SET_RGB: begin
        if (led < NumLeds) begin
          group = led / 12;
          k     = led % 12;
          cs    = group[0] ? 11 - k : k;
          for (int c = 0; c < 3; c++) queue_pixel(group * 3 + c, cs, levels[c]);
        end
      end
      OP_ALL_ON:  queue_fill(8'hFF);
      OP_ALL_OFF: queue_fill(8'h00);
      OP_LOW_OFF: begin
        queue_prelude(PageOnoff);
        queue_byte(OnoffStartReg, 1'b0);
        for (int i = 0; i < ShadowBytes / 2; i++) begin
          onoff_copy[i] = 8'h00;
          queue_byte(8'h00, i == ShadowBytes / 2 - 1);
        end
      end
      OP_HIGH_OFF: begin
        queue_prelude(PageOnoff);
        queue_byte(OnoffStartReg, 1'b0);
        for (int i = 0; i < ShadowBytes / 2; i++) queue_byte(onoff_copy[i], 1'b0);
        for (int i = ShadowBytes / 2; i < ShadowBytes; i++) begin
          onoff_copy[i] = 8'h00;
          queue_byte(8'h00, i == ShadowBytes - 1);
        end
      end
      default: ;
    endcase
    if (pending_bytes.size() > start) begin
      tail      = pending_bytes.pop_back();
      tail.last = 1'b1;
      pending_bytes.push_back(tail);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    bus_byte_t want;
    if (!rst_ni) begin
      foreach (onoff_copy[i]) onoff_copy[i] = 8'h00;
      pending_bytes.delete();
      pending_o <= 0;
    end else begin
      // Retire the output byte first: a command never yields a byte at its own transfer.
      if (out_valid_i && out_ready_i) begin
        if (pending_bytes.size() == 0) begin
          report_mismatch($sformatf("unexpected byte 0x%02h to 0x%02h",
                                    data_byte_i, bus_addr_i));
        end else begin
          want = pending_bytes.pop_front();
          if (bus_addr_i !== want.addr)
            report_mismatch($sformatf("bus_addr got 0x%02h want 0x%02h",
                                      bus_addr_i, want.addr));
          if (data_byte_i !== want.data)
            report_mismatch($sformatf("data_byte got 0x%02h want 0x%02h",
                                      data_byte_i, want.data));
          if (end_of_transfer_i !== want.eot)
            report_mismatch($sformatf("end_of_transfer got %b want %b",
                                      end_of_transfer_i, want.eot));
          if (last_i !== want.last)
            report_mismatch($sformatf("last got %b want %b", last_i, want.last));
        end
      end
      if (in_valid_i && in_ready_i)
        predict_command(op_i, device_addr_i, led_index_i,
                        red_level_i, green_level_i, blue_level_i);
      pending_o <= pending_bytes.size();
    end
  end

endmodule

// ===== tb/tb_rgb_led_matrix_write_sequencer_top.sv =====
`timescale 1ns / 100ps

module tb_rgb_led_matrix_write_sequencer_top;
  import rlm_pkg::*;

  // Op codes the block must take and drop without output.
  localparam logic [2:0] OpSpare6 = 3'd6;
  localparam logic [2:0] OpSpare7 = 3'd7;

  localparam int RandomPerPhase = 105;
  localparam int TailCycles     = 60;

  logic       clk_i          = 1'b0;
  logic       rst_ni         = 1'b0;
  logic       in_valid_i     = 1'b0;
  logic       in_ready_o;
  logic [2:0] op_i           = 3'd0;
  logic [7:0] device_addr_i  = 8'd0;
  logic [5:0] led_index_i    = 6'd0;
  logic [7:0] red_level_i    = 8'd0;
  logic [7:0] green_level_i  = 8'd0;
  logic [7:0] blue_level_i   = 8'd0;
  logic       out_valid_o;
  logic       out_ready_i    = 1'b0;
  logic [7:0] bus_addr_o;
  logic [7:0] data_byte_o;
  logic       end_of_transfer_o;
  logic       last_o;

  int fail_count;
  int bytes_pending;

  // Percent of cycles in which the sender idles or the receiver stalls.
  int send_idle  = 0;
  int recv_stall = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  rgb_led_matrix_write_sequencer_top dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .op_i              (op_i),
    .device_addr_i     (device_addr_i),
    .led_index_i       (led_index_i),
    .red_level_i       (red_level_i),
    .green_level_i     (green_level_i),
    .blue_level_i      (blue_level_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .bus_addr_o        (bus_addr_o),
    .data_byte_o       (data_byte_o),
    .end_of_transfer_o (end_of_transfer_o),
    .last_o            (last_o)
  );

  rlm_write_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_i        (in_ready_o),
    .op_i              (op_i),
    .device_addr_i     (device_addr_i),
    .led_index_i       (led_index_i),
    .red_level_i       (red_level_i),
    .green_level_i     (green_level_i),
    .blue_level_i      (blue_level_i),
    .out_valid_i       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .bus_addr_i        (bus_addr_o),
    .data_byte_i       (data_byte_o),
    .end_of_transfer_i (end_of_transfer_o),
    .last_i            (last_o),
    .fail_count_o      (fail_count),
    .pending_o         (bytes_pending)
  );

  // Stall the byte channel at random, once per cycle, at the current rate.
  always @(posedge clk_i) out_ready_i <= ($urandom_range(99) >= recv_stall);

  // Offer one command and hold it until the transfer happens. Idle first at
  // the current rate; valid stays high across back-to-back commands.
  task automatic send_cmd(input logic [2:0] op, input logic [7:0] addr,
                          input logic [5:0] led, input logic [7:0] red,
                          input logic [7:0] green, input logic [7:0] blue);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    op_i          <= op;
    device_addr_i <= addr;
    led_index_i   <= led;
    red_level_i   <= red;
    green_level_i <= green;
    blue_level_i  <= blue;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Drop valid and hold off until every predicted byte has come out.
  task automatic drain_bytes();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (bytes_pending != 0) @(posedge clk_i);
  endtask

  // Zero and full scale show up often so that colours switch off and on.
  function automatic logic [7:0] pick_level();
    int roll;
    roll = $urandom_range(99);
    if (roll < 25) return 8'd0;
    if (roll < 35) return 8'hFF;
    return 8'($urandom_range(255));
  endfunction

  // Mostly set rgb, so the on/off bytes build up; the bulk ops reshape them
  // now and then, with a few spare op codes and out-of-range LEDs as noise.
  task automatic run_random(input int count);
    int         roll;
    logic [2:0] op;
    logic [5:0] led;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(99);
      if (roll < 60)      op = OP_SET_RGB;
      else if (roll < 68) op = OP_ALL_ON;
      else if (roll < 76) op = OP_ALL_OFF;
      else if (roll < 83) op = OP_LOW_OFF;
      else if (roll < 90) op = OP_HIGH_OFF;
      else if (roll < 94) op = OP_INIT;
      else if (roll < 97) op = OpSpare6;
      else                op = OpSpare7;
      led = ($urandom_range(99) < 92) ? 6'($urandom_range(NumLeds - 1))
                                      : 6'($urandom_range(63, NumLeds));
      send_cmd(op, 8'($urandom_range(255)), led, pick_level(), pick_level(), pick_level());
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: every op, group edges of the LED table, zero and full levels,
    // clears after all on, both half-off orders, ignored LEDs and spare ops.
    send_cmd(OP_INIT,     8'h00, 6'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    send_cmd(OP_SET_RGB,  8'hFF, 6'd0,  8'hFF, 8'h01, 8'h80);
    send_cmd(OP_SET_RGB,  8'h3C, 6'd11, 8'hFF, 8'hFF, 8'hFF);
    send_cmd(OP_SET_RGB,  8'h3C, 6'd12, 8'h10, 8'h20, 8'h30);
    send_cmd(OP_SET_RGB,  8'h3C, 6'd23, 8'h7F, 8'h00, 8'hFE);
    send_cmd(OP_SET_RGB,  8'hC3, 6'd47, 8'h00, 8'h07, 8'h00);
    send_cmd(OP_SET_RGB,  8'hC3, 6'd0,  8'h00, 8'h00, 8'h00);
    send_cmd(OP_ALL_ON,   8'h5A, 6'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    send_cmd(OP_SET_RGB,  8'h5A, 6'd30, 8'h00, 8'h00, 8'h00);
    send_cmd(OP_HIGH_OFF, 8'h5A, 6'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    send_cmd(OP_LOW_OFF,  8'hA5, 6'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    send_cmd(OP_ALL_ON,   8'hA5, 6'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    send_cmd(OP_LOW_OFF,  8'hA5, 6'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    send_cmd(OP_HIGH_OFF, 8'h01, 6'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    send_cmd(OP_SET_RGB,  8'h01, 6'd5,  8'h01, 8'h02, 8'h03);
    send_cmd(OP_ALL_OFF,  8'h80, 6'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    send_cmd(OP_SET_RGB,  8'h80, 6'd48, 8'hFF, 8'hFF, 8'hFF);
    send_cmd(OP_SET_RGB,  8'h80, 6'd63, 8'h55, 8'hAA, 8'h0F);
    send_cmd(OpSpare6,    8'h80, 6'd1,  8'hFF, 8'hFF, 8'hFF);
    send_cmd(OpSpare7,    8'h80, 6'd2,  8'hFF, 8'hFF, 8'hFF);
    send_cmd(OP_SET_RGB,  8'h7E, 6'd47, 8'hFF, 8'hFF, 8'hFF);
    send_cmd(OP_SET_RGB,  8'h7E, 6'd36, 8'hF0, 8'h0F, 8'hAA);
    send_cmd(OP_INIT,     8'hA5, 6'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    drain_bytes();

    // Random phases: free flow, slow sender, slow receiver, both.
    send_idle  = 0;
    recv_stall = 0;
    run_random(RandomPerPhase);
    drain_bytes();
    send_idle  = 88;
    recv_stall = 0;
    run_random(RandomPerPhase);
    drain_bytes();
    send_idle  = 0;
    recv_stall = 88;
    run_random(RandomPerPhase);
    drain_bytes();
    send_idle  = 38;
    recv_stall = 38;
    run_random(RandomPerPhase);
    drain_bytes();

    // Let any stray byte surface before the verdict.
    repeat (TailCycles) @(posedge clk_i);
    if (fail_count == 0 && bytes_pending == 0) begin
      $display("rgb_led_matrix_write_sequencer_top regression: pass");
    end else begin
      $display("rgb_led_matrix_write_sequencer_top regression: fail");
    end
    $finish;
  end

  // Bound the run with a timeout far beyond the slowest correct run.
  initial begin
    #4_000_000;
    $display("rgb_led_matrix_write_sequencer_top regression: fail");
    $finish;
  end

endmodule
